FILE: src/triangle_from_three_lines_macros.svh
// Assertion macros used by the triangle-from-three-lines top level.
`ifndef TRIANGLE_FROM_THREE_LINES_MACROS_SVH
`define TRIANGLE_FROM_THREE_LINES_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define TFL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition in one cycle is followed by another in the next cycle.
`define TFL_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/tfl_pkg.sv
// Shared constants, types and latencies of the triangle-from-three-lines pipeline.
package tfl_pkg;

  localparam int TFL_COEF_WIDTH = 16;
  localparam int TFL_NUM_PAIRS = 3;
  localparam int TFL_COORD_W = 32;
  localparam int TFL_LEN_W = 31;
  localparam logic [TFL_LEN_W-1:0] TFL_LEN_MAX = {TFL_LEN_W{1'b1}};

  // Line pairs in result order: 1-2, 2-3, 1-3.
  localparam int TFL_PAIR_I [TFL_NUM_PAIRS] = '{0, 1, 0};
  localparam int TFL_PAIR_J [TFL_NUM_PAIRS] = '{1, 2, 2};

  // Divider: 40 quotient bits of num * 2^17 / den, two bits per stage.
  localparam int TFL_Q_BITS = 40;
  localparam int TFL_FRAC_SHIFT = 17;
  localparam int TFL_OVF_SHIFT = TFL_Q_BITS - TFL_FRAC_SHIFT;
  localparam int TFL_DIV_BPS = 2;
  localparam int TFL_DIV_LAT = TFL_Q_BITS / TFL_DIV_BPS + 2;

  // Square root: 32 result bits, two per stage, plus a rounding stage.
  localparam int TFL_SQ_ITERS = 32;
  localparam int TFL_SQ_BPS = 2;
  localparam int TFL_SQRT_LAT = TFL_SQ_ITERS / TFL_SQ_BPS + 1;

  // Geometry: difference, square, sum stages, then the square root.
  localparam int TFL_GEOM_LAT = 3 + TFL_SQRT_LAT;
  localparam int TFL_CRAMER_LAT = 2;
  localparam int TFL_TOTAL_LAT = TFL_CRAMER_LAT + TFL_DIV_LAT + TFL_GEOM_LAT;

  localparam int TFL_OUT_TDATA_W = 320;
  localparam int TFL_OUT_TUSER_W = 4;

  typedef logic signed [TFL_COORD_W-1:0] tfl_coord_t;

  // Intersection points and parallel flags carried alongside the geometry stages.
  typedef struct packed {
    logic [TFL_NUM_PAIRS-1:0]       mask;
    tfl_coord_t [TFL_NUM_PAIRS-1:0] px;
    tfl_coord_t [TFL_NUM_PAIRS-1:0] py;
  } tfl_pts_t;

endpackage

FILE: src/triangle_from_three_lines.sv
// Top level of the triangle-from-three-lines pipeline.

// Each input transaction carries three lines a*x + b*y = c with signed Q8.8
// coefficients, and it produces one output transaction for each. The block
// accepts one transaction every cycle unless the output is stalled; the rate
// is set by the fully pipelined dividers (two quotient bits per stage) and
// square-root units (two root bits per stage). Cross-product stages feed the
// division stages, which feed the geometry stages. The whole
// pipeline advances together: it moves whenever the output register is empty
// or being taken, so a stalled output holds every stage in place and nothing
// is lost or repeated. Intersection points of pairs 1-2, 2-3 and 1-3 are
// Q16.16, rounded to nearest with ties away from zero and saturated. A pair
// whose determinant is zero sets its parallel bit and reports the point as
// zero; if any pair is parallel, triangle_valid, the sides and the area are
// zero. Otherwise the sides are rounded square roots of the saturated point
// differences and the area is the rounded absolute shoelace area, both
// saturated to 2^31-1.
`include "triangle_from_three_lines_macros.svh"

module triangle_from_three_lines #(
  parameter int COEF_WIDTH = tfl_pkg::TFL_COEF_WIDTH
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // line1_a, line1_b, line1_c, line2_a, line2_b, line2_c, line3_a, line3_b,
  // line3_c, each COEF_WIDTH bits, then zero fill to whole bytes.
  input  logic [((9*COEF_WIDTH+7)/8)*8-1:0]    in_tdata,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // p12_x, p12_y, p23_x, p23_y, p13_x, p13_y (32 bits each), side_12_23,
  // side_23_13, side_12_13, tri_area (31 bits each), then zero fill.
  output logic [tfl_pkg::TFL_OUT_TDATA_W-1:0]  out_tdata,
  // parallel_mask (3 bits), triangle_valid (1 bit).
  output logic [tfl_pkg::TFL_OUT_TUSER_W-1:0]  out_tuser
);
  import tfl_pkg::*;

  localparam int DW = 2 * COEF_WIDTH + 1;
  localparam int LAST = TFL_TOTAL_LAT - 1;
  localparam int PT_BITS = 2 * TFL_NUM_PAIRS * TFL_COORD_W;
  localparam int LEN_BITS = (TFL_NUM_PAIRS + 1) * TFL_LEN_W;

  logic en;
  logic [TFL_TOTAL_LAT-1:0] vld_r;

  logic signed [COEF_WIDTH-1:0] a [TFL_NUM_PAIRS];
  logic signed [COEF_WIDTH-1:0] b [TFL_NUM_PAIRS];
  logic signed [COEF_WIDTH-1:0] c [TFL_NUM_PAIRS];
  logic signed [DW-1:0] det   [TFL_NUM_PAIRS];
  logic signed [DW-1:0] num_x [TFL_NUM_PAIRS];
  logic signed [DW-1:0] num_y [TFL_NUM_PAIRS];

  tfl_coord_t qx [TFL_NUM_PAIRS];
  tfl_coord_t qy [TFL_NUM_PAIRS];
  tfl_coord_t gx [TFL_NUM_PAIRS];
  tfl_coord_t gy [TFL_NUM_PAIRS];

  logic [TFL_NUM_PAIRS-1:0] mask_r [TFL_DIV_LAT];
  tfl_pts_t pts_nxt;
  tfl_pts_t pts_r [TFL_GEOM_LAT];
  tfl_pts_t pts_out;

  logic [TFL_LEN_W-1:0] side [TFL_NUM_PAIRS];
  logic [TFL_LEN_W-1:0] area;
  logic tri_ok;

  // The pipeline moves as one; a full output register that is not taken holds it.
  assign en        = !vld_r[LAST] || out_tready;
  assign in_tready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_tvalid};
    end
  end

  for (genvar k = 0; k < TFL_NUM_PAIRS; k++) begin : g_unpack
    assign a[k] = in_tdata[(3*k)*COEF_WIDTH +: COEF_WIDTH];
    assign b[k] = in_tdata[(3*k+1)*COEF_WIDTH +: COEF_WIDTH];
    assign c[k] = in_tdata[(3*k+2)*COEF_WIDTH +: COEF_WIDTH];
  end

  tfl_cramer #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_cramer (
    .clk   (clk),
    .en    (en),
    .a     (a),
    .b     (b),
    .c     (c),
    .det   (det),
    .num_x (num_x),
    .num_y (num_y)
  );

  for (genvar k = 0; k < TFL_NUM_PAIRS; k++) begin : g_div
    tfl_divider #(
      .COEF_WIDTH (COEF_WIDTH)
    ) u_div_x (
      .clk (clk),
      .en  (en),
      .num (num_x[k]),
      .den (det[k]),
      .quo (qx[k])
    );

    tfl_divider #(
      .COEF_WIDTH (COEF_WIDTH)
    ) u_div_y (
      .clk (clk),
      .en  (en),
      .num (num_y[k]),
      .den (det[k]),
      .quo (qy[k])
    );

    // A parallel pair has no intersection; its point reads as the origin.
    assign gx[k] = mask_r[TFL_DIV_LAT-1][k] ? '0 : qx[k];
    assign gy[k] = mask_r[TFL_DIV_LAT-1][k] ? '0 : qy[k];
    assign pts_nxt.px[k] = gx[k];
    assign pts_nxt.py[k] = gy[k];
  end

  assign pts_nxt.mask = mask_r[TFL_DIV_LAT-1];

  // Parallel flags ride beside the dividers, then the points ride beside the geometry.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TFL_NUM_PAIRS; k++) begin
        mask_r[0][k] <= (det[k] == '0);
      end
      for (int d = 1; d < TFL_DIV_LAT; d++) begin
        mask_r[d] <= mask_r[d-1];
      end
      pts_r[0] <= pts_nxt;
      for (int d = 1; d < TFL_GEOM_LAT; d++) begin
        pts_r[d] <= pts_r[d-1];
      end
    end
  end

  tfl_geom u_geom (
    .clk  (clk),
    .en   (en),
    .px   (gx),
    .py   (gy),
    .side (side),
    .area (area)
  );

  assign pts_out = pts_r[TFL_GEOM_LAT-1];
  assign tri_ok  = (pts_out.mask == '0);

  assign out_tvalid = vld_r[LAST];
  assign out_tdata  = {
    (TFL_OUT_TDATA_W - PT_BITS - LEN_BITS)'(0),
    tri_ok ? area    : '0,
    tri_ok ? side[2] : '0,
    tri_ok ? side[1] : '0,
    tri_ok ? side[0] : '0,
    pts_out.py[2], pts_out.px[2],
    pts_out.py[1], pts_out.px[1],
    pts_out.py[0], pts_out.px[0]
  };
  assign out_tuser  = {tri_ok, pts_out.mask};

  `TFL_ASSERT(a_stall_blocks_input, (out_tvalid && !out_tready) |-> !in_tready, "input taken while output stalled")
  `TFL_ASSERT_NEXT(a_accept_enters, in_tvalid && in_tready, vld_r[0], "accepted transaction did not enter the pipeline")
  `TFL_ASSERT(a_parallel_no_tri, (out_tvalid && (out_tuser[2:0] != 3'b000)) |-> (!out_tuser[3] && (out_tdata[PT_BITS +: LEN_BITS] == '0)), "triangle fields set with a parallel pair")
  `TFL_ASSERT(a_parallel_zero_pt, (out_tvalid && out_tuser[0]) |-> (out_tdata[2*TFL_COORD_W-1:0] == '0), "parallel pair 1-2 reported a nonzero point")

endmodule

FILE: src/tfl_cramer.sv
// Cramer's rule front end: cross products and determinants for the three line pairs.
module tfl_cramer #(
  parameter int COEF_WIDTH = tfl_pkg::TFL_COEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [COEF_WIDTH-1:0] a     [tfl_pkg::TFL_NUM_PAIRS],
  input  logic signed [COEF_WIDTH-1:0] b     [tfl_pkg::TFL_NUM_PAIRS],
  input  logic signed [COEF_WIDTH-1:0] c     [tfl_pkg::TFL_NUM_PAIRS],
  output logic signed [2*COEF_WIDTH:0] det   [tfl_pkg::TFL_NUM_PAIRS],
  output logic signed [2*COEF_WIDTH:0] num_x [tfl_pkg::TFL_NUM_PAIRS],
  output logic signed [2*COEF_WIDTH:0] num_y [tfl_pkg::TFL_NUM_PAIRS]
);
  import tfl_pkg::*;

  localparam int PW = 2 * COEF_WIDTH;
  localparam int DW = PW + 1;

  logic signed [PW-1:0] dp_r [TFL_NUM_PAIRS];
  logic signed [PW-1:0] dq_r [TFL_NUM_PAIRS];
  logic signed [PW-1:0] xp_r [TFL_NUM_PAIRS];
  logic signed [PW-1:0] xq_r [TFL_NUM_PAIRS];
  logic signed [PW-1:0] yp_r [TFL_NUM_PAIRS];
  logic signed [PW-1:0] yq_r [TFL_NUM_PAIRS];

  // Stage one: the six products of each pair.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TFL_NUM_PAIRS; k++) begin
        dp_r[k] <= a[TFL_PAIR_I[k]] * b[TFL_PAIR_J[k]];
        dq_r[k] <= a[TFL_PAIR_J[k]] * b[TFL_PAIR_I[k]];
        xp_r[k] <= c[TFL_PAIR_I[k]] * b[TFL_PAIR_J[k]];
        xq_r[k] <= c[TFL_PAIR_J[k]] * b[TFL_PAIR_I[k]];
        yp_r[k] <= a[TFL_PAIR_I[k]] * c[TFL_PAIR_J[k]];
        yq_r[k] <= a[TFL_PAIR_J[k]] * c[TFL_PAIR_I[k]];
      end
    end
  end

  // Stage two: exact differences, one bit wider than a product.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TFL_NUM_PAIRS; k++) begin
        det[k]   <= DW'(dp_r[k]) - DW'(dq_r[k]);
        num_x[k] <= DW'(xp_r[k]) - DW'(xq_r[k]);
        num_y[k] <= DW'(yp_r[k]) - DW'(yq_r[k]);
      end
    end
  end

endmodule

FILE: src/tfl_divider.sv
// Pipelined restoring divider giving round(num * 2^16 / den) saturated to Q16.16.
module tfl_divider #(
  parameter int COEF_WIDTH = tfl_pkg::TFL_COEF_WIDTH
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic signed [2*COEF_WIDTH:0] num,
  input  logic signed [2*COEF_WIDTH:0] den,
  output tfl_pkg::tfl_coord_t          quo
);
  import tfl_pkg::*;

  localparam int MW  = 2 * COEF_WIDTH;
  localparam int RW  = MW + TFL_Q_BITS;
  localparam int NST = TFL_Q_BITS / TFL_DIV_BPS;
  localparam logic [TFL_Q_BITS-1:0] LIM_POS = TFL_Q_BITS'((64'(1) << (TFL_COORD_W - 1)) - 64'(1));
  localparam logic [TFL_Q_BITS-1:0] LIM_NEG = TFL_Q_BITS'(64'(1) << (TFL_COORD_W - 1));

  logic [MW-1:0]         num_mag;
  logic [MW-1:0]         den_mag;
  logic                  ovf_c;
  logic [RW-1:0]         rem_r [NST+1];
  logic [TFL_Q_BITS-1:0] q_r   [NST+1];
  logic [MW-1:0]         d_r   [NST+1];
  logic                  neg_r [NST+1];
  logic                  ovf_r [NST+1];
  logic [TFL_Q_BITS:0]   rnd;
  logic [TFL_Q_BITS-1:0] mag;
  logic [TFL_Q_BITS-1:0] lim;
  logic [TFL_Q_BITS-1:0] mag_sat;

  assign num_mag = num[MW] ? MW'(-num) : num[MW-1:0];
  assign den_mag = den[MW] ? MW'(-den) : den[MW-1:0];
  // The quotient reaches 2^40 exactly when num >= den * 2^23.
  assign ovf_c   = RW'(num_mag) >= (RW'(den_mag) << TFL_OVF_SHIFT);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(num_mag) << TFL_FRAC_SHIFT;
      q_r[0]   <= '0;
      d_r[0]   <= den_mag;
      neg_r[0] <= num[MW] ^ den[MW];
      ovf_r[0] <= ovf_c;
    end
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [RW-1:0]         rem_c;
    logic [TFL_Q_BITS-1:0] q_c;
    logic [RW:0]           trial;

    always_comb begin
      rem_c = rem_r[s];
      q_c   = q_r[s];
      trial = '0;
      for (int bb = 0; bb < TFL_DIV_BPS; bb++) begin
        trial = {1'b0, rem_c} - ({1'b0, RW'(d_r[s])} << (TFL_Q_BITS - 1 - s * TFL_DIV_BPS - bb));
        if (!trial[RW]) begin
          rem_c = trial[RW-1:0];
          q_c[TFL_Q_BITS - 1 - s * TFL_DIV_BPS - bb] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1] <= rem_c;
        q_r[s+1]   <= q_c;
        d_r[s+1]   <= d_r[s];
        neg_r[s+1] <= neg_r[s];
        ovf_r[s+1] <= ovf_r[s];
      end
    end
  end

  // Round half away from zero on the extra fraction bit, then saturate.
  assign rnd     = {1'b0, q_r[NST]} + (TFL_Q_BITS+1)'(1);
  assign mag     = rnd[TFL_Q_BITS:1];
  assign lim     = neg_r[NST] ? LIM_NEG : LIM_POS;
  assign mag_sat = (ovf_r[NST] || (mag > lim)) ? lim : mag;

  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_r[NST] ? -TFL_COORD_W'(mag_sat) : TFL_COORD_W'(mag_sat);
    end
  end

endmodule

FILE: src/tfl_sqrt.sv
// Pipelined digit-by-digit square root of a 63-bit value, rounded to nearest.
module tfl_sqrt (
  input  logic                            clk,
  input  logic                            en,
  input  logic [62:0]                     rad,
  output logic [tfl_pkg::TFL_LEN_W-1:0]   root
);
  import tfl_pkg::*;

  localparam int NST = TFL_SQ_ITERS / TFL_SQ_BPS;

  logic [63:0] n_r   [NST];
  logic [63:0] res_r [NST];
  logic [63:0] fin;

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [63:0] n_in;
    logic [63:0] res_in;
    logic [63:0] n_c;
    logic [63:0] res_c;
    logic [63:0] bitv;
    logic [64:0] sum;

    if (s == 0) begin : g_first
      assign n_in   = {1'b0, rad};
      assign res_in = '0;
    end else begin : g_next
      assign n_in   = n_r[s-1];
      assign res_in = res_r[s-1];
    end

    always_comb begin
      n_c   = n_in;
      res_c = res_in;
      bitv  = '0;
      sum   = '0;
      for (int bb = 0; bb < TFL_SQ_BPS; bb++) begin
        bitv = 64'(1) << (62 - 2 * (s * TFL_SQ_BPS + bb));
        sum  = {1'b0, res_c} + {1'b0, bitv};
        if ({1'b0, n_c} >= sum) begin
          n_c   = n_c - sum[63:0];
          res_c = (res_c >> 1) + bitv;
        end else begin
          res_c = res_c >> 1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[s]   <= n_c;
        res_r[s] <= res_c;
      end
    end
  end

  // A remainder above the root means the true root lies past the half point.
  assign fin = res_r[NST-1] + 64'(n_r[NST-1] > res_r[NST-1]);

  always_ff @(posedge clk) begin
    if (en) begin
      root <= (fin > 64'(TFL_LEN_MAX)) ? TFL_LEN_MAX : fin[TFL_LEN_W-1:0];
    end
  end

endmodule

FILE: src/tfl_geom.sv
// Side lengths and shoelace area of the triangle spanned by the three points.
module tfl_geom (
  input  logic                          clk,
  input  logic                          en,
  input  tfl_pkg::tfl_coord_t           px   [tfl_pkg::TFL_NUM_PAIRS],
  input  tfl_pkg::tfl_coord_t           py   [tfl_pkg::TFL_NUM_PAIRS],
  output logic [tfl_pkg::TFL_LEN_W-1:0] side [tfl_pkg::TFL_NUM_PAIRS],
  output logic [tfl_pkg::TFL_LEN_W-1:0] area
);
  import tfl_pkg::*;

  // Sides in result order: 12-23, 23-13, 12-13.
  localparam int SA [TFL_NUM_PAIRS] = '{0, 1, 0};
  localparam int SB [TFL_NUM_PAIRS] = '{1, 2, 2};

  function automatic logic [31:0] abs33(input logic signed [32:0] v);
    abs33 = v[32] ? 32'(-v) : v[31:0];
  endfunction

  logic signed [32:0] dx [TFL_NUM_PAIRS];
  logic signed [32:0] dy [TFL_NUM_PAIRS];
  logic [31:0]        adx [TFL_NUM_PAIRS];
  logic [31:0]        ady [TFL_NUM_PAIRS];
  logic signed [32:0] ad [4];

  logic [TFL_LEN_W-1:0] ax_r [TFL_NUM_PAIRS];
  logic [TFL_LEN_W-1:0] ay_r [TFL_NUM_PAIRS];
  logic [TFL_NUM_PAIRS-1:0] sat1_r, sat2_r, sat3_r;
  logic [TFL_NUM_PAIRS-1:0] satd_r [TFL_SQRT_LAT];
  logic [31:0] am_r [4];
  logic        an_r [4];

  logic [61:0] sqx_r [TFL_NUM_PAIRS];
  logic [61:0] sqy_r [TFL_NUM_PAIRS];
  logic [63:0] p1_r, p2_r;
  logic        n1_r, n2_r;

  logic [62:0] rad_r [TFL_NUM_PAIRS];
  logic signed [65:0] s1, s2, cr;
  logic [64:0] amag_r;

  logic [65:0] rnd;
  logic [48:0] sh;
  logic [TFL_LEN_W-1:0] area_r [TFL_SQRT_LAT];
  logic [TFL_LEN_W-1:0] root [TFL_NUM_PAIRS];

  always_comb begin
    for (int k = 0; k < TFL_NUM_PAIRS; k++) begin
      dx[k]  = 33'(px[SA[k]]) - 33'(px[SB[k]]);
      dy[k]  = 33'(py[SA[k]]) - 33'(py[SB[k]]);
      adx[k] = abs33(dx[k]);
      ady[k] = abs33(dy[k]);
    end
    // Cross product terms: (x23-x12)*(y13-y12) - (x13-x12)*(y23-y12).
    ad[0] = 33'(px[1]) - 33'(px[0]);
    ad[1] = 33'(py[2]) - 33'(py[0]);
    ad[2] = 33'(px[2]) - 33'(px[0]);
    ad[3] = 33'(py[1]) - 33'(py[0]);
  end

  // Stage one: magnitudes, and flags for sides too long to square.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TFL_NUM_PAIRS; k++) begin
        ax_r[k]   <= adx[k][TFL_LEN_W-1:0];
        ay_r[k]   <= ady[k][TFL_LEN_W-1:0];
        sat1_r[k] <= adx[k][31] | ady[k][31];
      end
      for (int m = 0; m < 4; m++) begin
        am_r[m] <= abs33(ad[m]);
        an_r[m] <= ad[m][32];
      end
    end
  end

  // Stage two: squares and area products.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TFL_NUM_PAIRS; k++) begin
        sqx_r[k] <= 62'(ax_r[k]) * 62'(ax_r[k]);
        sqy_r[k] <= 62'(ay_r[k]) * 62'(ay_r[k]);
      end
      sat2_r <= sat1_r;
      p1_r   <= 64'(am_r[0]) * 64'(am_r[1]);
      p2_r   <= 64'(am_r[2]) * 64'(am_r[3]);
      n1_r   <= an_r[0] ^ an_r[1];
      n2_r   <= an_r[2] ^ an_r[3];
    end
  end

  assign s1 = n1_r ? -$signed(66'(p1_r)) : $signed(66'(p1_r));
  assign s2 = n2_r ? -$signed(66'(p2_r)) : $signed(66'(p2_r));
  assign cr = s1 - s2;

  // Stage three: sums of squares and the absolute cross product.
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < TFL_NUM_PAIRS; k++) begin
        rad_r[k] <= {1'b0, sqx_r[k]} + {1'b0, sqy_r[k]};
      end
      sat3_r <= sat2_r;
      amag_r <= cr[65] ? 65'(-cr) : cr[64:0];
    end
  end

  // Half the cross product, rounded half up to Q16.16.
  assign rnd = {1'b0, amag_r} + 66'(65536);
  assign sh  = rnd[65:17];

  always_ff @(posedge clk) begin
    if (en) begin
      area_r[0] <= (sh > 49'(TFL_LEN_MAX)) ? TFL_LEN_MAX : sh[TFL_LEN_W-1:0];
      for (int d = 1; d < TFL_SQRT_LAT; d++) begin
        area_r[d] <= area_r[d-1];
      end
      satd_r[0] <= sat3_r;
      for (int d = 1; d < TFL_SQRT_LAT; d++) begin
        satd_r[d] <= satd_r[d-1];
      end
    end
  end

  for (genvar k = 0; k < TFL_NUM_PAIRS; k++) begin : g_side
    tfl_sqrt u_sqrt (
      .clk  (clk),
      .en   (en),
      .rad  (rad_r[k]),
      .root (root[k])
    );
    assign side[k] = satd_r[TFL_SQRT_LAT-1][k] ? TFL_LEN_MAX : root[k];
  end

  assign area = area_r[TFL_SQRT_LAT-1];

endmodule
